// ===== sv/frame_rate_monitor_limiter_macros.svh =====
// ----------------------------------------------------------------------------
// frame rate monitor and limiter assertion macros
// Concurrent assertion forms used by the block's controller, frml_ctrl.
// ----------------------------------------------------------------------------
`ifndef FRAME_RATE_MONITOR_LIMITER_MACROS_SVH
`define FRAME_RATE_MONITOR_LIMITER_MACROS_SVH

// same-cycle implication, disabled during reset
`define FRML_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define FRML_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/frml_pkg.sv =====
// ----------------------------------------------------------------------------
// frml_pkg
// Types and constants shared by the frame rate monitor and limiter modules.
// ----------------------------------------------------------------------------
package frml_pkg;

	// frame time history
	localparam int WINDOW  = 10;
	localparam int RING_AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W  = $clog2(WINDOW + 1);
	localparam int FRAME_W = 16;
	localparam int SUM_W   = 20;

	// field widths
	localparam int TICK_W  = 32;
	localparam int FPS_W   = 22;
	localparam int DELAY_W = 10;
	localparam int CFG_W   = 10;

	// arithmetic constants
	localparam int FPS_NUM       = 1000 * 256;
	localparam int FPS_DEFAULT   = 60 * 256;
	localparam int BUDGET_NUM    = 1000;
	localparam int MAX_FPS_RESET = 60;
	localparam int FRAME_MAX     = (1 << FRAME_W) - 1;

	// divider geometry
	localparam int DIV_NW = FPS_W;
	localparam int DIV_DW = SUM_W;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	// action codes
	localparam logic ACT_BEGIN = 1'b0;
	localparam logic ACT_END   = 1'b1;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_FPS_GO,
		S_FPS,
		S_BUD,
		S_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic take_begin;
		logic take_end;
		logic update;
		logic div_start;
		logic div_bud;
		logic fps_load;
		logic bud_load;
		logic out_load;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic div_busy;
		logic div_done;
	} sts_t;

endpackage

// ===== sv/frame_rate_monitor_limiter.sv =====
// ----------------------------------------------------------------------------
// frame_rate_monitor_limiter
// Frame rate monitor with a moving-average rate and a frame budget wait.
// ----------------------------------------------------------------------------
// A frame-begin request (action 0) only records its tick. A frame-end
// request (action 1) gives one result: the time since the previous end, the
// average rate over up to the last ten frames in Q.8 and the wait still
// needed to stay under max_fps. With the result register free a frame end
// occupies the block through its acceptance, the window update, the divider
// start, the two runs of the shared one-bit-per-cycle divider (22 quotient
// steps and a done pulse each, rate first, then budget) and the result
// load; input is stalled meanwhile. A finished result sits in an output
// register, so a new request is taken while it waits; a following frame
// end stalls only at the point where its own result would need that
// register. max_fps comes through cfg_we/cfg_wdata; the user must write it
// only while no request is in progress; the block does not enforce this.
module frame_rate_monitor_limiter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [frml_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic [frml_pkg::TICK_W-1:0]  now_ms,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [frml_pkg::FRAME_W-1:0] frame_ms,
	output logic [frml_pkg::FPS_W-1:0]   fps_q8,
	output logic [frml_pkg::DELAY_W-1:0] delay_ms
);
	import frml_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	frml_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic and storage
	frml_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.now_ms    (now_ms),
		.cmd       (cmd),
		.sts       (sts),
		.frame_ms  (frame_ms),
		.fps_q8    (fps_q8),
		.delay_ms  (delay_ms)
	);

endmodule

// ===== sv/frml_div.sv =====
// ----------------------------------------------------------------------------
// frml_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frml_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [frml_pkg::DIV_NW-1:0] num,
	input  logic [frml_pkg::DIV_DW-1:0] den,
	output logic                        busy,
	output logic                        done,
	output logic [frml_pkg::DIV_NW-1:0] quo
);
	import frml_pkg::*;

	logic [DIV_DW:0]   rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              done_q;
	logic [DIV_DW:0]   rem_sh;
	logic [DIV_DW:0]   trial;
	logic              fits;

	// one trial subtraction
	always_comb begin
		rem_sh = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
		trial  = rem_sh - {1'b0, den_q};
		fits   = ~trial[DIV_DW];
	end

	// iteration count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CW'(1)) && !start;
			if (start)
				cnt_q <= DIV_CW'(DIV_NW);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - DIV_CW'(1);
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial : rem_sh;
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== sv/frml_dp.sv =====
// ----------------------------------------------------------------------------
// frml_dp
// Datapath: tick capture, frame time history, divider operands and result
// registers.
// ----------------------------------------------------------------------------
module frml_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [frml_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic [frml_pkg::TICK_W-1:0]  now_ms,
	input  frml_pkg::cmd_t               cmd,
	output frml_pkg::sts_t               sts,
	output logic [frml_pkg::FRAME_W-1:0] frame_ms,
	output logic [frml_pkg::FPS_W-1:0]   fps_q8,
	output logic [frml_pkg::DELAY_W-1:0] delay_ms
);
	import frml_pkg::*;

	logic [CFG_W-1:0]   max_fps_q;
	logic [TICK_W-1:0]  start_q;
	logic [TICK_W-1:0]  last_end_q;
	logic               primed_q;
	logic [TICK_W-1:0]  elapsed_q;
	logic [FRAME_W-1:0] frame_q;
	logic [FRAME_W-1:0] ring_q [WINDOW];
	logic [FRAME_W-1:0] oldest_q;
	logic [RING_AW-1:0] pos_q;
	logic [FILL_W-1:0]  fill_q;
	logic [SUM_W-1:0]   sum_q;
	logic [FPS_W-1:0]   fps_q;
	logic [DELAY_W-1:0] delay_q;
	logic [FRAME_W-1:0] frame_ms_q;
	logic [FPS_W-1:0]   fps_ms_q;
	logic [DELAY_W-1:0] delay_ms_q;

	logic [TICK_W-1:0]  diff;
	logic [FRAME_W-1:0] frame_new;
	logic               full;
	logic [SUM_W-1:0]   sum_new;
	logic [DIV_NW-1:0]  div_num;
	logic [DIV_DW-1:0]  div_den;
	logic [DIV_NW-1:0]  div_quo;
	logic               div_busy;
	logic               div_done;
	logic [TICK_W-1:0]  budget;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_fps_q <= CFG_W'(MAX_FPS_RESET);
		else if (cfg_we)
			max_fps_q <= cfg_wdata;
	end

	// saturated frame time since the previous end
	always_comb begin
		diff = now_ms - last_end_q;
		if (!primed_q)
			frame_new = '0;
		else if (diff > TICK_W'(FRAME_MAX))
			frame_new = FRAME_W'(FRAME_MAX);
		else
			frame_new = diff[FRAME_W-1:0];
	end

	// tick capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			last_end_q <= '0;
			primed_q   <= 1'b0;
		end else begin
			if (cmd.take_begin)
				start_q <= now_ms;
			if (cmd.take_end) begin
				last_end_q <= now_ms;
				primed_q   <= 1'b1;
			end
		end
	end

	// per-frame values held for the rest of the computation
	always_ff @(posedge clk) begin
		if (cmd.take_end) begin
			frame_q   <= frame_new;
			elapsed_q <= now_ms - start_q;
		end
	end

	// running window sum, oldest entry drops out once the ring is full
	always_comb begin
		full    = (fill_q == FILL_W'(WINDOW));
		sum_new = sum_q - (full ? SUM_W'(oldest_q) : SUM_W'(0)) + SUM_W'(frame_q);
	end

	// ring position, fill count and sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.update) begin
			sum_q  <= sum_new;
			pos_q  <= (pos_q == RING_AW'(WINDOW - 1)) ? '0 : pos_q + RING_AW'(1);
			if (!full)
				fill_q <= fill_q + FILL_W'(1);
		end
	end

	// frame time ring, entry about to be replaced is read as the frame end is taken
	always_ff @(posedge clk) begin
		if (cmd.take_end)
			oldest_q <= ring_q[pos_q];
		if (cmd.update)
			ring_q[pos_q] <= frame_q;
	end

	// divider operands: average rate or frame budget
	always_comb begin
		if (cmd.div_bud) begin
			div_num = DIV_NW'(BUDGET_NUM);
			div_den = (max_fps_q == '0) ? DIV_DW'(1) : DIV_DW'(max_fps_q);
		end else begin
			div_num = DIV_NW'(fill_q) * DIV_NW'(FPS_NUM);
			div_den = sum_q;
		end
	end

	frml_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign budget = TICK_W'(div_quo);

	// rate and remaining wait
	always_ff @(posedge clk) begin
		if (cmd.fps_load)
			fps_q <= (sum_q == '0) ? FPS_W'(FPS_DEFAULT) : div_quo;
		if (cmd.bud_load)
			delay_q <= (budget > elapsed_q) ? DELAY_W'(budget - elapsed_q) : '0;
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			frame_ms_q <= frame_q;
			fps_ms_q   <= fps_q;
			delay_ms_q <= delay_q;
		end
	end

	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign frame_ms     = frame_ms_q;
	assign fps_q8       = fps_ms_q;
	assign delay_ms     = delay_ms_q;

endmodule

// ===== sv/frml_ctrl.sv =====
// ----------------------------------------------------------------------------
// frml_ctrl
// Controller: request handshakes and sequencing of the update and the two
// divisions.
// ----------------------------------------------------------------------------
`include "frame_rate_monitor_limiter_macros.svh"

module frml_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           action,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  frml_pkg::sts_t sts,
	output frml_pkg::cmd_t cmd
);
	import frml_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign out_free = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (action == ACT_END) begin
						cmd.take_end = 1'b1;
						state_d      = S_UPD;
					end else begin
						cmd.take_begin = 1'b1;
					end
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_FPS_GO;
			end
			S_FPS_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_FPS;
			end
			S_FPS: begin
				if (sts.div_done) begin
					cmd.fps_load  = 1'b1;
					cmd.div_bud   = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = S_BUD;
				end
			end
			S_BUD: begin
				if (sts.div_done) begin
					cmd.bud_load = 1'b1;
					state_d      = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

	`FRML_ASSERT_IMP(a_div_start_idle, clk, arst_n, cmd.div_start && state_q == S_FPS_GO, !sts.div_busy, "divider started while busy")
	`FRML_ASSERT_IMP(a_div_done_state, clk, arst_n, sts.div_done, state_q == S_FPS || state_q == S_BUD, "divider finished outside a division state")
	`FRML_ASSERT_IMP(a_load_free, clk, arst_n, cmd.out_load, !out_valid_q || !out_stall, "result overwrites an untaken result")
	`FRML_ASSERT_NXT(a_load_valid, clk, arst_n, cmd.out_load, out_valid_q && state_q == S_IDLE, "loaded result not presented")

endmodule

// ===== sim/frame_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches the request, result and max_fps ports of the frame rate monitor,
// predicts each frame-end result and compares it field by field.
// ----------------------------------------------------------------------------
module frame_result_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [frml_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         action,
	input  logic [frml_pkg::TICK_W-1:0]  now_ms,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [frml_pkg::FRAME_W-1:0] frame_ms,
	input  logic [frml_pkg::FPS_W-1:0]   fps_q8,
	input  logic [frml_pkg::DELAY_W-1:0] delay_ms,
	output int                           fail_count,
	output int                           pending
);
	import frml_pkg::*;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [FPS_W-1:0]   fps;
		logic [DELAY_W-1:0] delay;
	} frame_result_t;

	// results owed by the block, oldest first
	frame_result_t expected_frames[$];
	frame_result_t want;

	// own copy of the block's state
	logic [CFG_W-1:0]   fps_ceiling;
	logic [TICK_W-1:0]  begin_stamp;
	logic [TICK_W-1:0]  end_stamp;
	logic               seen_end;
	logic [FRAME_W-1:0] history [WINDOW];
	int                 hist_pos;
	int                 hist_fill;
	logic [SUM_W-1:0]   history_sum;

	task report_fault(input string msg);
		$display("[%0t] frame check: %s", $time, msg);
		fail_count++;
	endtask

	// frame time, averaged rate and remaining budget for one frame end
	function frame_result_t predict_frame_end(input logic [TICK_W-1:0] stamp);
		logic [TICK_W-1:0] gap;
		logic [TICK_W-1:0] elapsed;
		logic [31:0]       budget;
		longint unsigned   rate;
		frame_result_t     res;
		if (seen_end) begin
			gap = stamp - end_stamp;
			res.frame = (gap > FRAME_MAX) ? FRAME_W'(FRAME_MAX) : gap[FRAME_W-1:0];
		end else begin
			res.frame = '0;
		end
		seen_end = 1'b1;
		end_stamp = stamp;

		// moving window of frame times
		if (hist_fill >= WINDOW)
			history_sum -= history[hist_pos];
		else
			hist_fill++;
		history[hist_pos] = res.frame;
		history_sum += res.frame;
		hist_pos = (hist_pos + 1 >= WINDOW) ? 0 : hist_pos + 1;

		if (history_sum == '0) begin
			res.fps = FPS_W'(FPS_DEFAULT);
		end else begin
			rate = (64'(FPS_NUM) * 64'(hist_fill)) / 64'(history_sum);
			res.fps = rate[FPS_W-1:0];
		end

		// a ceiling of zero counts as one frame per second
		budget = 32'(BUDGET_NUM) / ((fps_ceiling == '0) ? 32'd1 : 32'(fps_ceiling));
		elapsed = stamp - begin_stamp;
		res.delay = (budget > elapsed) ? DELAY_W'(budget - elapsed) : '0;
		return res;
	endfunction

	// track the ports; results are checked before a new request is queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_frames.delete();
			fps_ceiling = CFG_W'(MAX_FPS_RESET);
			begin_stamp = '0;
			end_stamp = '0;
			seen_end = 1'b0;
			hist_pos = 0;
			hist_fill = 0;
			history_sum = '0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_frames.size() == 0) begin
					report_fault($sformatf("unexpected result frame_ms %0d fps_q8 %0d delay_ms %0d",
						frame_ms, fps_q8, delay_ms));
				end else begin
					want = expected_frames.pop_front();
					if (frame_ms !== want.frame)
						report_fault($sformatf("frame_ms %0d, expected %0d", frame_ms, want.frame));
					if (fps_q8 !== want.fps)
						report_fault($sformatf("fps_q8 %0d, expected %0d", fps_q8, want.fps));
					if (delay_ms !== want.delay)
						report_fault($sformatf("delay_ms %0d, expected %0d", delay_ms, want.delay));
				end
			end
			if (in_valid && !in_stall) begin
				if (action == ACT_BEGIN)
					begin_stamp = now_ms;
				else
					expected_frames.push_back(predict_frame_end(now_ms));
			end
			if (cfg_we)
				fps_ceiling = cfg_wdata;
			pending = expected_frames.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives frame begin and end requests with random pacing on both channels,
// steps max_fps through its extremes and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
	import frml_pkg::*;

	localparam int SETTLE_CYCLES = 64;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_ITEMS   = 125;
	localparam int PHASES        = 6;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic               action;
	logic [TICK_W-1:0]  now_ms;
	logic               out_valid;
	logic               out_stall;
	logic [FRAME_W-1:0] frame_ms;
	logic [FPS_W-1:0]   fps_q8;
	logic [DELAY_W-1:0] delay_ms;

	int                 fault_count;
	int                 frames_waiting;
	int                 results_seen;
	int                 hold_mark;
	logic [TICK_W-1:0]  tick_ms;
	int                 ceiling_plan [PHASES] = '{1000, 1, 0, 1023, 60, 500};

	frame_rate_monitor_limiter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.frame_ms  (frame_ms),
		.fps_q8    (fps_q8),
		.delay_ms  (delay_ms)
	);

	frame_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_ms   (frame_ms),
		.fps_q8     (fps_q8),
		.delay_ms   (delay_ms),
		.fail_count (fault_count),
		.pending    (frames_waiting)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// overall time limit
	initial begin
		#40_000_000;
		$display("** frame_rate_monitor_limiter: FAILED **");
		$finish;
	end

	// delivered results, used to place the long receiver hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			results_seen <= 0;
		else if (out_valid && !out_stall)
			results_seen <= results_seen + 1;
	end

	// result side: random stalls, stall-free stretches and long hold-offs
	initial begin
		int pick;
		int run;
		out_stall = 1'b0;
		hold_mark = 120;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (results_seen >= hold_mark) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_mark += 200;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					out_stall <= 1'b0;
					run = $urandom_range(1, 6);
				end else if (pick < 90) begin
					out_stall <= 1'b1;
					run = $urandom_range(1, 3);
				end else if (pick < 97) begin
					out_stall <= 1'b1;
					run = $urandom_range(5, 25);
				end else begin
					out_stall <= 1'b0;
					run = $urandom_range(100, 300);
				end
				repeat (run - 1) @(negedge clk);
			end
		end
	end

	// offer one request and hold it until taken; returns on a falling edge
	task automatic send_request(input logic act, input logic [TICK_W-1:0] stamp);
		in_valid <= 1'b1;
		action <= act;
		now_ms <= stamp;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// random gap on the request side, mostly short
	task automatic sender_idle(input bit gapless);
		int pick;
		int len;
		if (!gapless) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				len = 0;
			else if (pick < 85)
				len = $urandom_range(1, 3);
			else if (pick < 97)
				len = $urandom_range(4, 20);
			else
				len = $urandom_range(40, 150);
			if (len > 0) begin
				in_valid <= 1'b0;
				repeat (len) @(negedge clk);
			end
		end
	endtask

	// stop offering and wait until every owed result is in and the block is quiet
	task automatic drain_results();
		in_valid <= 1'b0;
		while (frames_waiting != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_ceiling(input int value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly begin/end pairs with realistic timing, the rest stray requests
	task automatic run_frames(input int n_items, input bit gapless);
		int sent;
		int pick;
		int work;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				work = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1500) :
					$urandom_range(0, 30);
				send_request(ACT_BEGIN, tick_ms);
				sender_idle(gapless);
				tick_ms += work;
				send_request(ACT_END, tick_ms);
				tick_ms += $urandom_range(0, 8);
				if ($urandom_range(0, 49) == 0)
					tick_ms += $urandom_range(65536, 300000);
				sent += 2;
			end else if (pick < 88) begin
				tick_ms += $urandom_range(0, 40);
				send_request(ACT_END, tick_ms);
				sent++;
			end else if (pick < 94) begin
				send_request(ACT_BEGIN, tick_ms);
				sent++;
			end else begin
				send_request($urandom_range(0, 1) ? ACT_END : ACT_BEGIN, $urandom);
				sent++;
			end
			sender_idle(gapless);
		end
	endtask

	// stimulus and verdict
	initial begin
		int phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		action = ACT_BEGIN;
		now_ms = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first end after reset, end with no begin, zero window sum
		send_request(ACT_END, 32'd5);
		send_request(ACT_END, 32'd5);
		send_request(ACT_BEGIN, 32'd100);
		send_request(ACT_END, 32'd100);
		// tick wrap, elapsed beyond budget, saturated frame times
		send_request(ACT_BEGIN, 32'hFFFF_FFF0);
		send_request(ACT_END, 32'd5);
		send_request(ACT_END, 32'd70005);
		send_request(ACT_BEGIN, 32'hFFFF_FFFF);
		send_request(ACT_END, 32'hFFFF_FFFF);
		send_request(ACT_BEGIN, 32'd0);
		send_request(ACT_END, 32'd3);
		// zero ceiling gives the full second of budget
		write_ceiling(0);
		send_request(ACT_BEGIN, 32'd10);
		send_request(ACT_END, 32'd10);
		send_request(ACT_END, 32'd400);
		// ceiling above 1000 leaves no budget
		write_ceiling(1023);
		send_request(ACT_BEGIN, 32'd500);
		send_request(ACT_END, 32'd500);
		write_ceiling(1000);
		send_request(ACT_BEGIN, 32'd600);
		send_request(ACT_END, 32'd600);
		send_request(ACT_END, 32'd601);

		// random phases, one max_fps setting each
		ceiling_plan[PHASES - 1] = $urandom_range(2, 999);
		for (phase = 0; phase < PHASES; phase++) begin
			write_ceiling(ceiling_plan[phase]);
			tick_ms = phase[0] ? $urandom : 32'hFFFF_F000 + $urandom_range(0, 2048);
			run_frames(PHASE_ITEMS, phase == 2);
		end

		drain_results();
		if (fault_count == 0 && frames_waiting == 0)
			$display("** frame_rate_monitor_limiter: PASSED **");
		else
			$display("** frame_rate_monitor_limiter: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/frml_pkg.sv
sv/frml_div.sv
sv/frml_dp.sv
sv/frml_ctrl.sv
sv/frame_rate_monitor_limiter.sv
sim/frame_result_checker.sv
sim/testbench.sv
